>>> rtl/core/ptzcfb_pkg.sv
package ptzcfb_pkg;

  // Frame delimiters
  localparam logic [7:0] FRAME_START = 8'hA0;
  localparam logic [7:0] FRAME_END   = 8'hAF;

  // Field widths
  localparam int OPCODE_W = 5;
  localparam int BYTE_W   = 8;
  localparam int IN_W     = 48;  // 45 payload bits padded to whole bytes
  localparam int OUT_W    = 64;

  // Configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOVE_SPEED     = 1'b1;

  // Fixed argument bytes
  localparam logic [7:0] PRESET_PREPARE_ARG = 8'h60;
  localparam logic [7:0] SCAN_START_ARG     = 8'd97;
  localparam logic [7:0] SCAN_STOP_ARG      = 8'd96;
  localparam logic [7:0] CRUISE_SPEED_BASE  = 8'd9;

  // Command opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_STOP           = 5'd0,
    OP_LEFT           = 5'd1,
    OP_RIGHT          = 5'd2,
    OP_UP             = 5'd3,
    OP_DOWN           = 5'd4,
    OP_NEAR           = 5'd5,
    OP_FAR            = 5'd6,
    OP_ZOOM_OUT       = 5'd7,
    OP_ZOOM_IN        = 5'd8,
    OP_IRIS_OPEN      = 5'd9,
    OP_IRIS_CLOSE     = 5'd10,
    OP_LEFT_DOWN      = 5'd11,
    OP_LEFT_UP        = 5'd12,
    OP_RIGHT_DOWN     = 5'd13,
    OP_RIGHT_UP       = 5'd14,
    OP_PRESET_GO      = 5'd15,
    OP_PRESET_PREPARE = 5'd16,
    OP_PRESET_SET     = 5'd17,
    OP_CRUISE_RUN     = 5'd18,
    OP_CRUISE_STOP    = 5'd19,
    OP_CRUISE_DELETE  = 5'd20,
    OP_CRUISE_ENTER   = 5'd21,
    OP_CRUISE_CONFIG  = 5'd22,
    OP_CRUISE_LEAVE   = 5'd23,
    OP_TRACK_RECORD   = 5'd24,
    OP_TRACK_REC_STOP = 5'd25,
    OP_TRACK_START    = 5'd26,
    OP_TRACK_STOP     = 5'd27,
    OP_SCAN_START     = 5'd28,
    OP_SCAN_STOP      = 5'd29,
    OP_AUX_SET        = 5'd30,
    OP_AUX_CLEAR      = 5'd31
  } opcode_t;

endpackage

>>> rtl/core/ptz_command_frame_builder_top.sv
// Camera command frame builder: one 8-byte control frame per command word.
// An accepted word's frame is registered in the output register, or in the skid
// entry while the output holds a frame not being taken. Throughput: 1 word per
// cycle while the skid entry is empty; a 2-entry output buffer (register + skid)
// keeps input accepting while one frame waits at the output. Reset (rst,
// synchronous): output buffer emptied, device_address = 1, move_speed = 1.
module ptz_command_frame_builder_top (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ptzcfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ptzcfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  // command stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // opcode[4:0], preset_id[12:5], cruise_id[20:13], aux_number[28:21],
  // cruise_speed[36:29], wait_time[44:37], zero pad[47:45]
  input  logic [ptzcfb_pkg::IN_W-1:0]      s_axis_tdata,
  // frame stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // start_byte[7:0], address_byte[15:8], command_one[23:16],
  // command_two[31:24], data_one[39:32], data_two[47:40],
  // end_byte[55:48], check_byte[63:56]
  output logic [ptzcfb_pkg::OUT_W-1:0]     m_axis_tdata
);
  import ptzcfb_pkg::*;

  // Configuration registers
  logic [7:0] device_address;
  logic [3:0] move_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd1;
      move_speed     <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        REG_MOVE_SPEED:     move_speed     <= cfg_data[3:0];
        default:            ;
      endcase
    end
  end

  // Unpack command word
  opcode_t    opcode;
  logic [7:0] preset_id;
  logic [7:0] cruise_id;
  logic [7:0] aux_number;
  logic [7:0] cruise_speed;
  logic [7:0] wait_time;

  assign opcode       = opcode_t'(s_axis_tdata[4:0]);
  assign preset_id    = s_axis_tdata[12:5];
  assign cruise_id    = s_axis_tdata[20:13];
  assign aux_number   = s_axis_tdata[28:21];
  assign cruise_speed = s_axis_tdata[36:29];
  assign wait_time    = s_axis_tdata[44:37];

  // Derived argument bytes, all mod 256
  logic [7:0] speed_byte;
  logic [7:0] preset_plus;
  logic [7:0] cruise_step;
  logic       cruise_args_zero;

  assign speed_byte       = {1'b0, move_speed, 3'b000} - 8'd1;
  assign preset_plus      = preset_id + 8'd1;
  assign cruise_step      = CRUISE_SPEED_BASE - cruise_speed;
  assign cruise_args_zero = (preset_id == 8'd0) && (cruise_speed == 8'd0) &&
                            (wait_time == 8'd0);

  // Command decode
  logic [7:0] cmd1, cmd2, dat1, dat2;

  always_comb begin
    cmd1 = 8'd0;
    cmd2 = 8'd0;
    dat1 = 8'd0;
    dat2 = 8'd0;
    unique case (opcode)
      OP_STOP:           ;
      OP_LEFT:           begin cmd2 = 8'h04; dat1 = speed_byte; end
      OP_RIGHT:          begin cmd2 = 8'h02; dat1 = speed_byte; end
      OP_UP:             begin cmd2 = 8'h08; dat2 = speed_byte; end
      OP_DOWN:           begin cmd2 = 8'h10; dat2 = speed_byte; end
      OP_NEAR:           cmd1 = 8'h02;
      OP_FAR:            cmd1 = 8'h01;
      OP_ZOOM_OUT:       cmd2 = 8'h20;
      OP_ZOOM_IN:        cmd2 = 8'h40;
      OP_IRIS_OPEN:      cmd1 = 8'h04;
      OP_IRIS_CLOSE:     cmd1 = 8'h08;
      OP_LEFT_DOWN: begin
        cmd2 = 8'h14; dat1 = speed_byte; dat2 = speed_byte;
      end
      OP_LEFT_UP: begin
        cmd2 = 8'h0C; dat1 = speed_byte; dat2 = speed_byte;
      end
      OP_RIGHT_DOWN: begin
        cmd2 = 8'h12; dat1 = speed_byte; dat2 = speed_byte;
      end
      OP_RIGHT_UP: begin
        cmd2 = 8'h0A; dat1 = speed_byte; dat2 = speed_byte;
      end
      OP_PRESET_GO:      begin cmd2 = 8'h07; dat2 = preset_plus; end
      OP_PRESET_PREPARE: begin cmd2 = 8'h07; dat2 = PRESET_PREPARE_ARG; end
      OP_PRESET_SET:     begin cmd2 = 8'h03; dat2 = preset_plus; end
      OP_CRUISE_RUN:     begin cmd2 = 8'h4F; dat1 = 8'd1; dat2 = cruise_id; end
      OP_CRUISE_STOP:    cmd2 = 8'h51;
      OP_CRUISE_DELETE:  begin cmd2 = 8'h4D; dat2 = cruise_id; end
      OP_CRUISE_ENTER:   begin cmd2 = 8'h47; dat2 = cruise_id; end
      OP_CRUISE_CONFIG: begin
        // all-zero arguments send a zero preset byte
        cmd1 = cruise_args_zero ? 8'd0 : preset_plus;
        cmd2 = 8'h49;
        dat1 = cruise_step;
        dat2 = wait_time;
      end
      OP_CRUISE_LEAVE:   cmd2 = 8'h4B;
      OP_TRACK_RECORD:   cmd2 = 8'h1F;
      OP_TRACK_REC_STOP: cmd2 = 8'h21;
      OP_TRACK_START:    cmd2 = 8'h23;
      // stop track reuses the left-move code with zero speed
      OP_TRACK_STOP:     cmd2 = 8'h04;
      OP_SCAN_START:     begin cmd2 = 8'h07; dat2 = SCAN_START_ARG; end
      OP_SCAN_STOP:      begin cmd2 = 8'h07; dat2 = SCAN_STOP_ARG; end
      OP_AUX_SET:        begin cmd2 = 8'h09; dat2 = aux_number; end
      OP_AUX_CLEAR:      begin cmd2 = 8'h0B; dat2 = aux_number; end
    endcase
  end

  // Assemble frame with checksum
  logic [7:0]       addr_byte;
  logic [7:0]       check_byte;
  logic [OUT_W-1:0] frame;

  assign addr_byte  = device_address - 8'd1;
  assign check_byte = FRAME_START ^ addr_byte ^ cmd1 ^ cmd2 ^ dat1 ^ dat2 ^ FRAME_END;
  assign frame      = {check_byte, FRAME_END, dat2, dat1, cmd2, cmd1, addr_byte,
                       FRAME_START};

  // Output register plus skid entry
  logic             out_valid;
  logic [OUT_W-1:0] out_data;
  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;
  logic             in_take;
  logic             out_pop;

  assign s_axis_tready = !skid_valid;
  assign in_take       = s_axis_tvalid && !skid_valid;
  assign out_pop       = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid || out_pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload moves without reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_data <= skid_data;
      end
    end else if (in_take) begin
      if (!out_valid || out_pop) begin
        out_data <= frame;
      end else begin
        skid_data <= frame;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
